FILE: hdl/hhl_pkg.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer package
// Shared types, byte constants and character-class helpers of the lexer.
// ============================================================================
package hhl_pkg;

    localparam int BYTE_W  = 8;
    localparam int CLS_W   = 3;
    localparam int MAX_RES = 4;
    localparam int IDX_W   = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        M_TEXT, M_TAG, M_STR2, M_STR1, M_WORD, M_ENT, M_DTD, M_CMT
    } t_mode;

    typedef enum logic [CLS_W-1:0] {
        C_TEXT    = 3'd0,
        C_TAG     = 3'd1,
        C_STRING  = 3'd2,
        C_ENTITY  = 3'd3,
        C_COMMENT = 3'd4,
        C_KEYWORD = 3'd5
    } t_cls;

    // Where the open span starts after a byte: unchanged, at the current
    // offset, one past it, or two past it (saturated).
    typedef enum logic [1:0] {SP_KEEP, SP_P, SP_I, SP_P2} t_span_sel;

    typedef struct packed {
        logic      emit_tag;
        logic      emit_text;
        logic      set_mode;
        t_mode     mode;
        t_span_sel span_sel;
    } t_tag_res;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] n;
    } t_load_ctl;

    function automatic logic is_alpha(logic [BYTE_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(logic [BYTE_W-1:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Decision for one byte seen in tag mode. bang_ok is true when the '!'
    // stands one place after the span start, i.e. directly after '<'.
    function automatic t_tag_res tag_eval(logic [BYTE_W-1:0] c, logic is_end,
                                          logic bang_ok);
        t_tag_res r;
        r = '{emit_tag: 1'b0, emit_text: 1'b0, set_mode: 1'b0,
              mode: M_TAG, span_sel: SP_KEEP};
        if (is_end) begin
            r.emit_tag = 1'b1;
        end else if (c == CH_GT) begin
            r.emit_tag  = 1'b1;
            r.emit_text = 1'b1;
            r.set_mode  = 1'b1;
            r.mode      = M_TEXT;
            r.span_sel  = SP_I;
        end else if (c == CH_DQ) begin
            r.emit_tag = 1'b1;
            r.set_mode = 1'b1;
            r.mode     = M_STR2;
            r.span_sel = SP_P;
        end else if (c == CH_SQ) begin
            r.emit_tag = 1'b1;
            r.set_mode = 1'b1;
            r.mode     = M_STR1;
            r.span_sel = SP_P;
        end else if (c == CH_BANG) begin
            if (bang_ok) begin
                r.emit_tag = 1'b1;
                r.set_mode = 1'b1;
                r.mode     = M_DTD;
            end
        end else if (is_alpha(c)) begin
            r.emit_tag = 1'b1;
            r.set_mode = 1'b1;
            r.mode     = M_WORD;
            r.span_sel = SP_P;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/hhl_if.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer channels
// Valid/ready channels for input bytes and for colour-change results.
// ============================================================================
interface hhl_in_if;
    import hhl_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic [BYTE_W-1:0] next_byte;
    logic              first_of_line;

    modport source (output valid, output char_byte, output next_byte,
                    output first_of_line, input ready);
    modport sink   (input valid, input char_byte, input next_byte,
                    input first_of_line, output ready);
endinterface

interface hhl_out_if #(parameter int OFF_W = 13);
    import hhl_pkg::*;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] color_offset;
    logic [CLS_W-1:0] color_class;
    logic             last_result;

    modport source (output valid, output color_offset, output color_class,
                    output last_result, input ready);
    modport sink   (input valid, input color_offset, input color_class,
                    input last_result, output ready);
endinterface
`default_nettype wire

FILE: hdl/hhl_lex.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer step
// Input register, lexer state and the single-pass decode of one byte.
// ============================================================================
module hhl_lex #(
    parameter int MAX_LINE = 4096,
    parameter int OFF_W    = 13
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    hhl_in_if.sink                                       i_item,
    input  wire                                          i_q_free,
    output hhl_pkg::t_load_ctl                           o_ld,
    output logic [hhl_pkg::MAX_RES-1:0][OFF_W-1:0]       o_res_off,
    output logic [hhl_pkg::MAX_RES-1:0][hhl_pkg::CLS_W-1:0] o_res_cls
);
    import hhl_pkg::*;

    localparam int SUM_W = OFF_W + 2;
    localparam logic [SUM_W-1:0] MAX_W = SUM_W'(MAX_LINE);

    typedef struct packed {
        logic [CNT_W-1:0]                n;
        logic [MAX_RES-1:0][OFF_W-1:0]   off;
        logic [MAX_RES-1:0][CLS_W-1:0]   cls;
    } t_emits;

    function automatic t_emits push(t_emits e, logic [OFF_W-1:0] off, t_cls cls);
        t_emits r;
        r = e;
        if (e.n < CNT_W'(MAX_RES)) begin
            r.off[e.n[IDX_W-1:0]] = off;
            r.cls[e.n[IDX_W-1:0]] = cls;
            r.n = e.n + CNT_W'(1);
        end
        return r;
    endfunction

    // Input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_char;
    logic [BYTE_W-1:0] r_next;
    logic              r_first;

    // Lexer state
    t_mode             r_mode;
    logic [OFF_W-1:0]  r_span;
    logic [OFF_W-1:0]  r_line;
    logic [BYTE_W-1:0] r_prev0;
    logic [BYTE_W-1:0] r_prev1;
    logic              r_skip;

    t_mode             n_mode;
    logic [OFF_W-1:0]  n_span;
    logic              n_skip;
    t_span_sel         sp_sel;

    logic              fire;
    logic [OFF_W-1:0]  s_cur, p, i_off, p2_off;
    logic [SUM_W-1:0]  s_w, p_w, i_w, p2_w;
    logic [BYTE_W-1:0] h0, h1;
    logic              skip, is_end, dash2, dtd_open, txt_chg;
    logic [BYTE_W-1:0] quote;
    t_tag_res          tr_tag, tr_word;
    t_emits            em;

    // No byte is taken while reset is held.
    assign fire         = r_in_vld && i_q_free;
    assign i_item.ready = i_rst_n && (!r_in_vld || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_char  <= i_item.char_byte;
            r_next  <= i_item.next_byte;
            r_first <= i_item.first_of_line;
        end
    end

    // A first byte of a line clears offset, span, history and the skip flag.
    assign s_cur = r_first ? '0 : r_span;
    assign p     = r_first ? '0 : r_line;
    assign h0    = r_first ? '0 : r_prev0;
    assign h1    = r_first ? '0 : r_prev1;
    assign skip  = r_first ? 1'b0 : r_skip;

    assign s_w    = SUM_W'(s_cur);
    assign p_w    = SUM_W'(p);
    assign i_w    = (p_w + SUM_W'(1) > MAX_W) ? MAX_W : p_w + SUM_W'(1);
    assign p2_w   = (p_w + SUM_W'(2) > MAX_W) ? MAX_W : p_w + SUM_W'(2);
    assign i_off  = i_w[OFF_W-1:0];
    assign p2_off = p2_w[OFF_W-1:0];

    assign is_end   = (r_char == CH_NUL) || (r_char == CH_LF);
    assign dash2    = (r_char == CH_DASH) && (r_next == CH_DASH);
    assign dtd_open = dash2 && (i_w == s_w + SUM_W'(3)) &&
                      (h0 == CH_BANG) && (h1 == CH_LT);
    assign txt_chg  = (r_char == CH_LT) || (r_char == CH_AMP);
    assign quote    = (r_mode == M_STR2) ? CH_DQ : CH_SQ;

    assign tr_tag  = tag_eval(r_char, is_end, i_w == s_w + SUM_W'(2));
    assign tr_word = tag_eval(r_char, is_end, i_w == p_w + SUM_W'(2));

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_skip = 1'b0;
        sp_sel = SP_KEEP;
        if (!skip) begin
            case (r_mode)
                M_TEXT: begin
                    if (r_char == CH_LT) begin
                        n_mode = M_TAG;
                    end else if (r_char == CH_AMP) begin
                        n_mode = M_ENT;
                    end
                    if ((is_end || txt_chg) && (s_w < i_w)) begin
                        sp_sel = SP_P;
                    end
                end
                M_TAG: begin
                    if (tr_tag.set_mode) begin
                        n_mode = tr_tag.mode;
                    end
                    sp_sel = tr_tag.span_sel;
                end
                M_STR2, M_STR1: begin
                    if (r_char == quote) begin
                        n_mode = M_TAG;
                        sp_sel = SP_I;
                    end
                end
                M_WORD: begin
                    if (!is_alnum(r_char)) begin
                        n_mode = M_TAG;
                        sp_sel = SP_P;
                        if (tr_word.set_mode) begin
                            n_mode = tr_word.mode;
                        end
                        if (tr_word.span_sel != SP_KEEP) begin
                            sp_sel = tr_word.span_sel;
                        end
                    end
                end
                M_ENT: begin
                    if (is_end) begin
                        n_mode = M_TEXT;
                    end else if (r_char == CH_SEMI) begin
                        n_mode = M_TEXT;
                        sp_sel = SP_I;
                    end else if (is_space(r_char)) begin
                        n_mode = M_TEXT;
                    end
                end
                M_DTD: begin
                    if (dtd_open) begin
                        n_mode = M_CMT;
                        sp_sel = SP_P;
                    end else if (r_char == CH_GT) begin
                        n_mode = M_TEXT;
                        sp_sel = SP_I;
                    end
                end
                M_CMT: begin
                    if (dash2) begin
                        n_mode = M_DTD;
                        sp_sel = SP_P2;
                        n_skip = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_TEXT;
                end
            endcase
        end
    end

    always_comb begin
        case (sp_sel)
            SP_P:    n_span = p;
            SP_I:    n_span = i_off;
            SP_P2:   n_span = p2_off;
            default: n_span = s_cur;
        endcase
    end

    // Colour changes caused by this byte, in order
    always_comb begin
        em = '0;
        if (r_first) begin
            em = push(em, '0, C_TEXT);
        end
        if (!skip) begin
            case (r_mode)
                M_TEXT: begin
                    if ((is_end || txt_chg) && (s_w < i_w)) begin
                        em = push(em, s_cur, C_TEXT);
                    end
                end
                M_TAG: begin
                    if (tr_tag.emit_tag) begin
                        em = push(em, s_cur, C_TAG);
                    end
                    if (tr_tag.emit_text) begin
                        em = push(em, i_off, C_TEXT);
                    end
                end
                M_STR2, M_STR1: begin
                    if ((r_char == quote) || is_end) begin
                        em = push(em, s_cur, C_STRING);
                    end
                end
                M_WORD: begin
                    if (!is_alnum(r_char)) begin
                        em = push(em, s_cur, C_KEYWORD);
                        if (tr_word.emit_tag) begin
                            em = push(em, p, C_TAG);
                        end
                        if (tr_word.emit_text) begin
                            em = push(em, i_off, C_TEXT);
                        end
                    end
                end
                M_ENT: begin
                    if (is_end) begin
                        em = push(em, s_cur, C_TEXT);
                    end else if (r_char == CH_SEMI) begin
                        em = push(em, s_cur, C_ENTITY);
                    end
                end
                M_DTD: begin
                    if (dtd_open || (r_char == CH_GT) || is_end) begin
                        em = push(em, s_cur, C_TAG);
                    end
                end
                M_CMT: begin
                    if (dash2 || is_end) begin
                        em = push(em, s_cur, C_COMMENT);
                    end
                end
                default: begin
                    em = em;
                end
            endcase
        end
    end

    assign o_ld.load = fire;
    assign o_ld.n    = em.n;
    assign o_res_off = em.off;
    assign o_res_cls = em.cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_TEXT;
            r_span  <= '0;
            r_line  <= '0;
            r_prev0 <= '0;
            r_prev1 <= '0;
            r_skip  <= 1'b0;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_span  <= n_span;
            r_line  <= i_off;
            r_prev0 <= r_char;
            r_prev1 <= h0;
            r_skip  <= n_skip;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/hhl_res_q.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer result queue
// Holds one byte's colour changes; hands out one per cycle unless stalled.
// ============================================================================
module hhl_res_q #(
    parameter int OFF_W = 13
) (
    input  wire                                             i_clk,
    input  wire                                             i_rst_n,
    input  wire hhl_pkg::t_load_ctl                         i_ld,
    input  wire [hhl_pkg::MAX_RES-1:0][OFF_W-1:0]           i_res_off,
    input  wire [hhl_pkg::MAX_RES-1:0][hhl_pkg::CLS_W-1:0]  i_res_cls,
    output logic                                            o_free,
    hhl_out_if.source                                       o_color
);
    import hhl_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [OFF_W-1:0] r_off  [MAX_RES];
    logic [CLS_W-1:0] r_cls  [MAX_RES];
    logic             r_last [MAX_RES];
    logic             pop;

    assign pop    = o_color.valid && o_color.ready;
    assign o_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ld.load) begin
            r_cnt <= i_ld.n;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // The entry at the head is shown; a pop moves the rest one place on.
    always_ff @(posedge i_clk) begin
        if (i_ld.load) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_off[k]  <= i_res_off[k];
                r_cls[k]  <= i_res_cls[k];
                r_last[k] <= (CNT_W'(k + 1) == i_ld.n);
            end
        end else if (pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_off[k]  <= r_off[k+1];
                r_cls[k]  <= r_cls[k+1];
                r_last[k] <= r_last[k+1];
            end
        end
    end

    assign o_color.valid        = (r_cnt != '0);
    assign o_color.color_offset = r_off[0];
    assign o_color.color_class  = r_cls[0];
    assign o_color.last_result  = r_last[0];

endmodule
`default_nettype wire

FILE: hdl/html_highlight_lexer_core.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer core
// Byte-at-a-time HTML lexer that reports colour changes for highlighting.
// ============================================================================
// Usage. Each item on i_item is one byte of a line, the byte after it (for
// the dash lookahead of comments) and a flag marking the first byte of a line.
// Each byte yields zero to four items on o_color, each an offset and a colour
// class; the last item belonging to a byte carries last_result. The lexer mode
// carries over from line to line.
// A byte accepted on i_item passes the input register and then the result
// queue before its first colour change shows on o_color. Throughput: one byte
// per cycle while each byte gives at most one result and the receiver is ready;
// a byte with more results holds the lexer while the queue drains one per cycle.
// Reset (synchronous, active low) returns the lexer to plain text with all
// offsets and history cleared and empties the result queue. When the receiver
// stalls, results wait in the queue, the next byte waits in the input
// register, and i_item.ready falls once both are occupied.
// ============================================================================
module html_highlight_lexer_core #(
    parameter int MAX_LINE = 4096
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hhl_in_if.sink     i_item,
    hhl_out_if.source  o_color
);
    import hhl_pkg::*;

    // Offsets run from 0 up to and including the line size.
    localparam int OFF_W = $clog2(MAX_LINE + 1);

    t_load_ctl                     w_ld;
    logic                          w_q_free;
    logic [MAX_RES-1:0][OFF_W-1:0] w_res_off;
    logic [MAX_RES-1:0][CLS_W-1:0] w_res_cls;

    // The lexer step decodes one registered byte per cycle whenever the
    // result queue will be empty at the next edge.
    hhl_lex #(
        .MAX_LINE (MAX_LINE),
        .OFF_W    (OFF_W)
    ) u_lex (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_q_free  (w_q_free),
        .o_ld      (w_ld),
        .o_res_off (w_res_off),
        .o_res_cls (w_res_cls)
    );

    // The queue holds every colour change of one byte and presents them in
    // order, and the next byte is decoded only once the queue is about to empty.
    hhl_res_q #(
        .OFF_W (OFF_W)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (w_ld),
        .i_res_off (w_res_off),
        .i_res_cls (w_res_cls),
        .o_free    (w_q_free),
        .o_color   (o_color)
    );

`ifndef SYNTH
    // A byte is decoded only when its results cannot overwrite waiting ones.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld.load |-> w_q_free)
        else $error("byte decoded while the result queue was still busy");

    // A result that is not the last of its byte is always followed by another.
    a_batch_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_color.valid && o_color.ready && !o_color.last_result) |=> o_color.valid)
        else $error("results of one byte ended without last_result");

    // A byte never gives more colour changes than the queue can hold.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld.load |-> (w_ld.n <= CNT_W'(MAX_RES)))
        else $error("too many results for one byte");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/html_highlight_lexer_core_tb.sv
`default_nettype none
// ============================================================================
// HTML highlight lexer core testbench
// Sends HTML-like lines into the lexer one byte per item and checks every
// colour change that comes back against a byte-level lexer kept in the
// testbench. The run has a short directed part, then random lines with
// malformed noise, a long receiver stall that fills the block and stalls
// its input, and one long line that mixes every construct.
// ============================================================================
module html_highlight_lexer_core_tb;
    import hhl_pkg::*;

    localparam int MAX_LINE     = 4096;
    localparam int OFF_W        = 13;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT      = 5000000;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        t_cls             cls;
        logic             last;
    } color_change_t;

    // Tracks the lexer state byte by byte and keeps the colour changes that
    // the block still owes, oldest first.
    class color_change_checker;
        t_mode         mode;
        int            span;
        int            offset;
        logic [7:0]    prev1;
        logic [7:0]    prev2;
        bit            skip;
        int            errors;
        color_change_t step_q[$];
        color_change_t expected_changes[$];

        function new();
            mode   = M_TEXT;
            span   = 0;
            offset = 0;
            prev1  = 8'h00;
            prev2  = 8'h00;
            skip   = 1'b0;
            errors = 0;
        endfunction

        function int clamp(int x);
            return (x > MAX_LINE) ? MAX_LINE : x;
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        endfunction

        function bit alnum(logic [7:0] c);
            return letter(c) || (c >= 8'h30 && c <= 8'h39);
        endfunction

        function bit blank(logic [7:0] c);
            return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function void push_change(int off, t_cls cls);
            if (step_q.size() < MAX_RES)
                step_q.push_back('{off: OFF_W'(off), cls: cls, last: 1'b0});
        endfunction

        function void tag_step(logic [7:0] c, int p, int i, bit is_end);
            if (is_end) begin
                push_change(span, C_TAG);
            end else if (c == CH_GT) begin
                push_change(span, C_TAG);
                span = i;
                push_change(span, C_TEXT);
                mode = M_TEXT;
            end else if (c == CH_DQ || c == CH_SQ) begin
                push_change(span, C_TAG);
                span = p;
                mode = (c == CH_DQ) ? M_STR2 : M_STR1;
            end else if (c == CH_BANG) begin
                // Only a '!' directly after '<' opens a declaration.
                if (i == span + 2) begin
                    push_change(span, C_TAG);
                    mode = M_DTD;
                end
            end else if (letter(c)) begin
                push_change(span, C_TAG);
                span = p;
                mode = M_WORD;
            end
        endfunction

        function void take_byte(logic [7:0] c, logic [7:0] nx, bit first);
            int p;
            int i;
            bit is_end;
            step_q.delete();
            if (first) begin
                offset = 0;
                span   = 0;
                prev1  = 8'h00;
                prev2  = 8'h00;
                skip   = 1'b0;
                push_change(0, C_TEXT);
            end
            p      = clamp(offset);
            i      = clamp(p + 1);
            is_end = (c == CH_NUL) || (c == CH_LF);
            if (skip) begin
                // Second dash of a comment close: nothing is lexed.
                skip = 1'b0;
            end else begin
                case (mode)
                    M_TEXT: begin
                        if (c == CH_LT)
                            mode = M_TAG;
                        else if (c == CH_AMP)
                            mode = M_ENT;
                        if ((is_end || mode != M_TEXT) && span < i) begin
                            push_change(span, C_TEXT);
                            span = p;
                        end
                    end
                    M_TAG: tag_step(c, p, i, is_end);
                    M_STR2, M_STR1: begin
                        if (c == ((mode == M_STR2) ? CH_DQ : CH_SQ)) begin
                            push_change(span, C_STRING);
                            span = i;
                            mode = M_TAG;
                        end else if (is_end) begin
                            push_change(span, C_STRING);
                        end
                    end
                    M_WORD: begin
                        // The byte that ends a word is handled again as a tag byte.
                        if (!alnum(c)) begin
                            push_change(span, C_KEYWORD);
                            span = p;
                            mode = M_TAG;
                            tag_step(c, p, i, is_end);
                        end
                    end
                    M_ENT: begin
                        if (is_end) begin
                            push_change(span, C_TEXT);
                            mode = M_TEXT;
                        end else if (c == CH_SEMI) begin
                            push_change(span, C_ENTITY);
                            span = i;
                            mode = M_TEXT;
                        end else if (blank(c)) begin
                            mode = M_TEXT;
                        end
                    end
                    M_DTD: begin
                        if (c == CH_DASH && nx == CH_DASH && i == span + 3 &&
                                prev1 == CH_BANG && prev2 == CH_LT) begin
                            push_change(span, C_TAG);
                            span = p;
                            mode = M_CMT;
                        end else if (c == CH_GT) begin
                            push_change(span, C_TAG);
                            span = i;
                            mode = M_TEXT;
                        end else if (is_end) begin
                            push_change(span, C_TAG);
                        end
                    end
                    default: begin
                        if (c == CH_DASH && nx == CH_DASH) begin
                            push_change(span, C_COMMENT);
                            span = clamp(p + 2);
                            skip = 1'b1;
                            mode = M_DTD;
                        end else if (is_end) begin
                            push_change(span, C_COMMENT);
                        end
                    end
                endcase
            end
            prev2  = prev1;
            prev1  = c;
            offset = i;
            if (step_q.size() > 0)
                step_q[$].last = 1'b1;
            foreach (step_q[k])
                expected_changes.push_back(step_q[k]);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void check_change(logic [OFF_W-1:0] off, logic [CLS_W-1:0] cls,
                                   logic last);
            color_change_t want;
            if (expected_changes.size() == 0) begin
                report($sformatf("unexpected colour change: offset %0d class %0d last %0b",
                                 off, cls, last));
                return;
            end
            want = expected_changes.pop_front();
            if (off !== want.off || cls !== want.cls || last !== want.last)
                report($sformatf({"colour change mismatch: expected offset %0d class %0d",
                                  " last %0b, got offset %0d class %0d last %0b"},
                                 want.off, want.cls, want.last, off, cls, last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hhl_in_if                 byte_if ();
    hhl_out_if #(.OFF_W(OFF_W)) color_if ();

    html_highlight_lexer_core #(
        .MAX_LINE (MAX_LINE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (byte_if),
        .o_color (color_if)
    );

    color_change_checker checker_h = new();

    logic [7:0] line_buf[$];
    int         bytes_sent;
    bit         idling;
    bit         hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver side: random stall bursts, or one long hold-off on request.
    initial begin : color_ready_driver
        int n;
        color_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                color_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (idling && $urandom_range(0, 99) < 25) begin
                n = $urandom_range(1, 3);
                color_if.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                color_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && color_if.valid && color_if.ready)
            checker_h.check_change(color_if.color_offset, color_if.color_class,
                                   color_if.last_result);
    end

    task automatic send_byte(input logic [7:0] c, input logic [7:0] nx, input bit first);
        int gap;
        gap = (idling && $urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            byte_if.valid = 1'b0;
        end
        @(negedge i_clk);
        byte_if.valid         = 1'b1;
        byte_if.char_byte     = c;
        byte_if.next_byte     = nx;
        byte_if.first_of_line = first;
        do @(posedge i_clk); while (!byte_if.ready);
        checker_h.take_byte(c, nx, first);
        bytes_sent++;
    endtask

    // A noisy line gets random lookahead bytes and may restart mid-line.
    task automatic send_line(input bit mark_first, input bit noisy);
        int k;
        int mid;
        logic [7:0] nx;
        mid = noisy ? int'($urandom_range(0, line_buf.size())) : -1;
        for (k = 0; k < line_buf.size(); k++) begin
            nx = (k + 1 < line_buf.size()) ? line_buf[k+1] : CH_NUL;
            if (noisy && $urandom_range(0, 3) == 0)
                nx = 8'($urandom_range(0, 255));
            send_byte(line_buf[k], nx, (k == 0 && mark_first) || k == mid);
        end
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h61, 8'h7A))
                                           : 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endfunction

    function automatic void add_name();
        int n;
        n = $urandom_range(0, 4);
        line_buf.push_back(rand_letter());
        repeat (n)
            line_buf.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                                           : rand_letter());
    endfunction

    function automatic void add_token();
        logic [7:0] quote;
        case ($urandom_range(0, 9))
            0, 1: begin
                repeat ($urandom_range(1, 6)) line_buf.push_back(rand_letter());
                line_buf.push_back(CH_SPACE);
            end
            2: begin
                add_str("<");
                add_name();
                add_str(">");
            end
            3: begin
                quote = ($urandom_range(0, 1) != 0) ? CH_DQ : CH_SQ;
                add_str("<");
                add_name();
                add_str(" ");
                add_name();
                add_str("=");
                line_buf.push_back(quote);
                repeat ($urandom_range(0, 5)) line_buf.push_back(8'($urandom_range(32, 126)));
                line_buf.push_back(quote);
                add_str(">");
            end
            4: begin
                add_str("</");
                add_name();
                add_str(">");
            end
            5: begin
                add_str("&");
                add_name();
                line_buf.push_back(($urandom_range(0, 2) != 0) ? CH_SEMI : CH_SPACE);
            end
            6: begin
                add_str("<!--");
                repeat ($urandom_range(0, 4)) line_buf.push_back(rand_letter());
                if ($urandom_range(0, 2) == 0)
                    add_str(" -- x ");
                add_str("-->");
            end
            7: begin
                add_str("<!");
                add_name();
                add_str(" x>");
            end
            8: begin
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: add_str("<");
                    1: add_str("<!-");
                    2: add_str("--");
                    3: add_str("&");
                    4: add_str("\"");
                    default: add_str("<a 'b");
                endcase
            end
        endcase
    endfunction

    task automatic send_random_line();
        int r;
        line_buf.delete();
        repeat ($urandom_range(1, 5)) add_token();
        r = $urandom_range(0, 9);
        if (r < 7)
            line_buf.push_back(CH_LF);
        else if (r < 9)
            line_buf.push_back(CH_NUL);
        send_line($urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
    endtask

    initial begin : stimulus
        i_rst_n               = 1'b0;
        byte_if.valid         = 1'b0;
        byte_if.char_byte     = 8'h00;
        byte_if.next_byte     = 8'h00;
        byte_if.first_of_line = 1'b0;
        bytes_sent            = 0;
        idling                = 1'b1;
        hold_off_req          = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tag, word end on a blank, string, entity, then a
        // comment with its skipped dash and a NUL end, then bytes after
        // the end of the line and the top byte value.
        line_buf.delete();
        add_str("<b x=\"y\">&z;\n");
        send_line(1'b1, 1'b0);
        line_buf.delete();
        add_str("<!--c-->");
        line_buf.push_back(CH_NUL);
        send_line(1'b1, 1'b0);
        send_byte(8'hFF, 8'hFF, 1'b0);
        send_byte(8'h41, 8'h00, 1'b1);

        while (bytes_sent < 200) begin
            if ($urandom_range(0, 7) == 0)
                idling = ($urandom_range(0, 3) != 0);
            send_random_line();
        end

        // The receiver holds off while bytes keep coming without gaps.
        idling       = 1'b0;
        hold_off_req = 1'b1;
        while (bytes_sent < 250)
            send_random_line();

        // One long line: a run of words, then every construct in a row.
        idling = 1'b1;
        line_buf.delete();
        repeat (40)
            line_buf.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE : rand_letter());
        add_str("<ab c=\"d\" e='f'>&g;<!--h-->x<!y>");
        line_buf.push_back(CH_LF);
        send_line(1'b1, 1'b0);

        while (bytes_sent < 380)
            send_random_line();
        idling = 1'b0;
        while (bytes_sent < 460)
            send_random_line();

        @(negedge i_clk);
        byte_if.valid = 1'b0;
        while (checker_h.expected_changes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        foreach (checker_h.expected_changes[k])
            checker_h.report($sformatf("missing colour change: offset %0d class %0d",
                                       checker_h.expected_changes[k].off,
                                       checker_h.expected_changes[k].cls));

        if (checker_h.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
